[hw/rtl/swm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window maximum filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_BITS    = 7;
    localparam int CNT_BITS    = $clog2(MAX_WINDOW);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WIN_BITS-1:0]           win_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;

    localparam win_t    WINDOW_RESET = win_t'(8);
    localparam win_t    WINDOW_LIMIT = win_t'(MAX_WINDOW);
    localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Control handed from the sequencer to every cell
    typedef struct packed {
        logic load;   // shift in a new sample and reload the accumulators
        logic step;   // one reduction step toward cell 0
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

[hw/rtl/sliding_window_maximum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum filter over a signed sample stream, built as a chain of
// identical cells that hold the sample history and reduce it to one max.
// ----------------------------------------------------------------------------
// Each accepted sample beat shifts into a history line of MAX_WINDOW cells.
// Once window_size samples have arrived since reset, each sample beat yields
// one result beat: the largest of the last window_size samples, the new one
// included; before that a sample yields nothing. A window_size of zero acts
// as one, and anything above MAX_WINDOW acts as MAX_WINDOW. A sample that
// gives no result is only loaded. A sample that gives a result is loaded,
// then takes window_size - 1 reduction steps (window clamped as above) in
// which the partial max moves one cell toward the head of the chain per
// cycle, then is handed to the output register once any earlier result has
// been taken. No sample is taken during a reduction. The next sample is taken while that result waits for
// m_ready. Write window_size only while the block is idle; the new size
// applies from the next sample.
// ----------------------------------------------------------------------------
module sliding_window_maximum (
    input  logic             aclk,
    input  logic             aresetn,
    // sample input
    input  logic             s_valid,
    output logic             s_ready,
    input  swm_pkg::sample_t s_sample,
    // window size register write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  swm_pkg::win_t    cfg_window_size,
    // window max output
    output logic             m_valid,
    input  logic             m_ready,
    output swm_pkg::sample_t m_window_max
);

    swm_pkg::cell_ctl_t ctl;
    swm_pkg::win_t      win_eff;
    logic               capture;

    // line_q[k] holds the sample of age k; acc_q[k] the partial max at cell k
    swm_pkg::sample_t   line_q [swm_pkg::MAX_WINDOW];
    swm_pkg::sample_t   acc_q  [swm_pkg::MAX_WINDOW];
    swm_pkg::sample_t   max_reg, max_next;

    swm_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_window_size (cfg_window_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .ctl             (ctl),
        .win_eff         (win_eff),
        .capture         (capture)
    );

    for (genvar k = 0; k < swm_pkg::MAX_WINDOW; k++) begin : g_cell
        swm_pkg::sample_t line_in;
        swm_pkg::sample_t acc_in;
        logic             in_window;

        // the cell takes part only if its age falls inside the window
        assign in_window = (win_eff > swm_pkg::win_t'(k));

        if (k == 0) begin : g_head
            assign line_in = s_sample;
        end else begin : g_body
            assign line_in = line_q[k-1];
        end

        if (k == swm_pkg::MAX_WINDOW - 1) begin : g_tail
            assign acc_in = swm_pkg::SAMPLE_MIN;
        end else begin : g_link
            assign acc_in = acc_q[k+1];
        end

        swm_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .in_window (in_window),
            .line_in   (line_in),
            .acc_in    (acc_in),
            .line_out  (line_q[k]),
            .acc_out   (acc_q[k])
        );
    end

    // Output register: load the head accumulator when the reduction is done,
    // hold while the beat waits.
    always_comb begin
        max_next = max_reg;
        if (capture) begin
            max_next = acc_q[0];
        end
    end

    always_ff @(posedge aclk) begin
        max_reg <= max_next;
    end

    assign m_window_max = max_reg;

endmodule

[hw/rtl/swm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the chain: a sample tap of the history line and one
// accumulator of the max reduction.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic               aclk,
    input  swm_pkg::cell_ctl_t ctl,
    input  logic               in_window,
    input  swm_pkg::sample_t   line_in,
    input  swm_pkg::sample_t   acc_in,
    output swm_pkg::sample_t   line_out,
    output swm_pkg::sample_t   acc_out
);

    swm_pkg::sample_t line_reg, line_next;
    swm_pkg::sample_t acc_reg,  acc_next;

    always_comb begin
        line_next = line_reg;
        acc_next  = acc_reg;
        if (ctl.load) begin
            line_next = line_in;
            acc_next  = in_window ? line_in : swm_pkg::SAMPLE_MIN;
        end else if (ctl.step) begin
            // pull the neighbor's partial max one cell closer to the head
            if (acc_in > acc_reg) begin
                acc_next = acc_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        line_reg <= line_next;
        acc_reg  <= acc_next;
    end

    assign line_out = line_reg;
    assign acc_out  = acc_reg;

endmodule

[hw/rtl/swm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: window register, fill count, reduction step counter and the
// output beat valid.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  swm_pkg::win_t      cfg_window_size,
    output logic               m_valid,
    input  logic               m_ready,
    output swm_pkg::cell_ctl_t ctl,
    output swm_pkg::win_t      win_eff,
    output logic               capture
);

    swm_pkg::state_t state_reg, state_next;
    swm_pkg::win_t   window_reg, window_next;
    swm_pkg::win_t   fill_reg, fill_next;
    swm_pkg::win_t   fill_inc;
    swm_pkg::cnt_t   cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (window_reg == '0) begin
            win_eff = swm_pkg::win_t'(1);
        end else if (window_reg > swm_pkg::WINDOW_LIMIT) begin
            win_eff = swm_pkg::WINDOW_LIMIT;
        end else begin
            win_eff = window_reg;
        end
    end

    assign fill_inc = (fill_reg == swm_pkg::WINDOW_LIMIT) ? fill_reg
                                                          : fill_reg + 1'b1;

    always_comb begin
        state_next   = state_reg;
        window_next  = window_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        ctl          = '0;
        capture      = 1'b0;
        s_ready      = 1'b0;

        if (cfg_valid) begin
            window_next = cfg_window_size;
        end

        case (state_reg)
            swm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load  = 1'b1;
                    fill_next = fill_inc;
                    if (fill_inc >= win_eff) begin
                        state_next = swm_pkg::ST_SCAN;
                        cnt_next   = swm_pkg::cnt_t'(win_eff - 1'b1);
                    end
                end
            end
            swm_pkg::ST_SCAN: begin
                if (cnt_reg != '0) begin
                    ctl.step = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end else if (!m_valid_reg || m_ready) begin
                    // hand the max at the head cell to the output register
                    capture      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swm_pkg::ST_IDLE;
            window_reg  <= swm_pkg::WINDOW_RESET;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
